[src/mom_pkg.sv]
// Shared types and constants for the MIDI output merger.
// Depends on nothing; used by mom_msg_tracker and midi_output_merger.
package mom_pkg;

  // Default sizing handed down from the top level.
  localparam int unsigned SOURCES_DEF     = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 64;

  // Stream payload widths (fields packed from bit 0, padded to whole bytes).
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned SOURCE_W    = 4;

  // Request kinds carried on in_tuser.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // MIDI byte codes.
  localparam logic [7:0] MIDI_STATUS_MIN  = 8'h80;
  localparam logic [7:0] MIDI_SYS_MIN     = 8'hF0;
  localparam logic [7:0] MIDI_SYSEX_START = 8'hF0;
  localparam logic [7:0] MIDI_TIME_CODE   = 8'hF1;
  localparam logic [7:0] MIDI_SONG_POS    = 8'hF2;
  localparam logic [7:0] MIDI_SONG_SEL    = 8'hF3;
  localparam logic [7:0] MIDI_SYSEX_END   = 8'hF7;
  localparam logic [7:0] MIDI_REALTIME_MIN = 8'hF8;
  localparam logic [7:0] MIDI_CLOCK       = 8'hF8;
  localparam logic [7:0] MIDI_ACT_SENSE   = 8'hFE;

  // Status high nibbles.
  localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
  localparam logic [3:0] HI_SYSTEM      = 4'hF;

  // Message parser state seen by the merger control.
  typedef struct packed {
    logic       in_sysex;
    logic [1:0] data_rem;
  } msg_state_t;

endpackage

[src/mom_msg_tracker.sv]
// Tracks the open MIDI message on the merged output: data bytes still due
// and system exclusive state. Depends on mom_pkg.
module mom_msg_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                sent,      // a byte left on the output
  input  logic [7:0]          sent_byte,
  output mom_pkg::msg_state_t msg_state
);

  mom_pkg::msg_state_t state_r;
  mom_pkg::msg_state_t state_nxt;

  // Update from the byte just sent; real-time bytes leave everything alone.
  always_comb begin
    state_nxt = state_r;
    if (sent && sent_byte < mom_pkg::MIDI_REALTIME_MIN) begin
      if (sent_byte < mom_pkg::MIDI_STATUS_MIN) begin
        if (state_r.data_rem != 2'd0) begin
          state_nxt.data_rem = state_r.data_rem - 2'd1;
        end
      end else begin
        state_nxt.in_sysex = 1'b0;
        case (sent_byte[7:4]) inside
          mom_pkg::HI_PROG_CHANGE, mom_pkg::HI_CHAN_PRESS: begin
            state_nxt.data_rem = 2'd1;
          end
          mom_pkg::HI_SYSTEM: begin
            case (sent_byte) inside
              mom_pkg::MIDI_SYSEX_START: begin
                state_nxt.in_sysex = 1'b1;
                state_nxt.data_rem = 2'd0;
              end
              mom_pkg::MIDI_TIME_CODE, mom_pkg::MIDI_SONG_SEL: begin
                state_nxt.data_rem = 2'd1;
              end
              mom_pkg::MIDI_SONG_POS: begin
                state_nxt.data_rem = 2'd2;
              end
              default: begin
                state_nxt.data_rem = 2'd0;
              end
            endcase
          end
          default: begin
            state_nxt.data_rem = 2'd2;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign msg_state = state_r;

endmodule

[src/midi_output_merger.sv]
// MIDI output merger: per-source byte FIFOs in one queue memory, per-source
// pointers and running status in a pointer memory. Depends on mom_pkg and
// mom_msg_tracker.
// Sequencing: push and tick requests read the pointer memory on accept and give
// their result from S_META; a tick that reads a source FIFO goes on to S_DATA
// for the registered queue memory read. One request is in flight at a time, so a
// new request is not taken until the last one is through and the output is free.
// Reset: control state clears synchronously; pointer memory entries read as
// zero until first written (per-entry valid bits); queue memory is not cleared.
module midi_output_merger #(
  parameter int unsigned SOURCES     = mom_pkg::SOURCES_DEF,
  parameter int unsigned QUEUE_DEPTH = mom_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mom_pkg::IN_TDATA_W-1:0]  in_tdata,  // source[3:0], data_byte[11:4],
                                                     // tx_ready[12], zero pad
  input  logic                            in_tuser,  // func: 0 push, 1 tick
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mom_pkg::OUT_TDATA_W-1:0] out_tdata  // tx_valid[0], tx_byte[8:1],
                                                     // activity[9], overrun[10], zero pad
);

  localparam int unsigned SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int unsigned RW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = CW + 1;
  localparam int unsigned MW = RW + CW + 8;
  localparam int unsigned QN = SOURCES * QUEUE_DEPTH;
  localparam int unsigned AW = $clog2(QN);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_META = 3'b010,
    S_DATA = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Captured request.
  logic              func_r;
  logic [SW-1:0]     src_r;
  logic              src_ok_r;
  logic [7:0]        byte_r;
  logic              ready_r;

  // Merger state.
  logic [SW-1:0]     active_r, active_nxt;
  logic [7:0]        held_r, held_nxt;
  logic              held_vld_r, held_vld_nxt;
  logic [7:0]        cur_r, cur_nxt;
  logic              await_r, await_nxt;

  // Output register.
  logic              out_vld_r;
  logic [mom_pkg::OUT_TDATA_W-1:0] out_data_r;

  // Pointer memory: read index, fill count, remembered status per source.
  logic [MW-1:0]     meta_mem [SOURCES];
  logic [SOURCES-1:0] meta_vld_r;
  logic [MW-1:0]     meta_q_r;
  logic              meta_q_vld_r;
  logic [SW-1:0]     meta_raddr;
  logic              meta_we;
  logic [SW-1:0]     meta_waddr;
  logic [MW-1:0]     meta_wdata;

  // Queue memory.
  logic [7:0]        queue_mem [QN];
  logic [7:0]        queue_q_r;
  logic              queue_we;
  logic              queue_re;
  logic [AW-1:0]     queue_addr;

  // Decoded pointer entry.
  logic [RW-1:0]     rd_idx;
  logic [CW-1:0]     fill;
  logic [7:0]        rstat;
  logic [PW-1:0]     wr_pos;
  logic [RW-1:0]     rd_idx_inc;

  // Result assembly.
  logic              res_vld;
  logic              emit_en;
  logic [7:0]        emit_byte;
  logic              overrun;
  logic              tx_go;
  logic [7:0]        tx_byte;
  logic              activity;

  logic              accept;
  logic [SW-1:0]     in_src_idx;
  logic              in_src_ok;

  mom_pkg::msg_state_t msg_state;

  mom_msg_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .sent      (tx_go),
    .sent_byte (emit_byte),
    .msg_state (msg_state)
  );

  // Handshake: one request at a time, output register must be free.
  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE) && (!out_vld_r || out_tready);
  assign in_src_idx = SW'(in_tdata[mom_pkg::SOURCE_W-1:0]);
  assign in_src_ok  = 32'(in_tdata[mom_pkg::SOURCE_W-1:0]) < 32'(SOURCES);
  assign meta_raddr = (in_tuser == mom_pkg::FUNC_TICK) ? active_r : in_src_idx;

  // Pointer entry fields; an entry never written reads as zero.
  assign rd_idx = meta_q_vld_r ? meta_q_r[MW-1 -: RW] : '0;
  assign fill   = meta_q_vld_r ? meta_q_r[CW+7:8] : '0;
  assign rstat  = meta_q_vld_r ? meta_q_r[7:0] : '0;

  // Write position in the ring and the advanced read index.
  always_comb begin
    wr_pos = PW'(rd_idx) + PW'(fill);
    if (wr_pos >= PW'(QUEUE_DEPTH)) begin
      wr_pos = wr_pos - PW'(QUEUE_DEPTH);
    end
    rd_idx_inc = (rd_idx == RW'(QUEUE_DEPTH - 1)) ? '0 : rd_idx + RW'(1);
  end

  // Request sequencing and state update.
  always_comb begin
    state_nxt    = state_r;
    active_nxt   = active_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    cur_nxt      = cur_r;
    await_nxt    = await_r;
    res_vld      = 1'b0;
    emit_en      = 1'b0;
    overrun      = 1'b0;
    meta_we      = 1'b0;
    meta_waddr   = src_r;
    meta_wdata   = {rd_idx, fill, rstat};
    queue_we     = 1'b0;
    queue_re     = 1'b0;
    queue_addr   = AW'(src_r) * AW'(QUEUE_DEPTH) + AW'(rd_idx);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_META;
        end
      end
      S_META: begin
        state_nxt = S_IDLE;
        res_vld   = 1'b1;
        if (func_r == mom_pkg::FUNC_PUSH) begin
          // Queue the byte, or flag overrun on a full FIFO.
          if (src_ok_r) begin
            if (fill >= CW'(QUEUE_DEPTH)) begin
              overrun = 1'b1;
            end else begin
              queue_we   = 1'b1;
              queue_addr = AW'(src_r) * AW'(QUEUE_DEPTH) + AW'(wr_pos);
              meta_we    = 1'b1;
              meta_wdata = {rd_idx, fill + CW'(1), rstat};
            end
          end
        end else if (await_r) begin
          emit_en = 1'b1;
        end else if (held_vld_r) begin
          cur_nxt      = held_r;
          held_vld_nxt = 1'b0;
          emit_en      = 1'b1;
        end else if (fill != '0) begin
          // Fetch the next byte of the active source.
          queue_re   = 1'b1;
          queue_addr = AW'(active_r) * AW'(QUEUE_DEPTH) + AW'(rd_idx);
          res_vld    = 1'b0;
          state_nxt  = S_DATA;
        end else if (!msg_state.in_sysex && msg_state.data_rem == 2'd0) begin
          // Source drained and no message open: move round-robin.
          active_nxt = (active_r == SW'(SOURCES - 1)) ? '0 : active_r + SW'(1);
        end
      end
      S_DATA: begin
        state_nxt  = S_IDLE;
        res_vld    = 1'b1;
        emit_en    = 1'b1;
        cur_nxt    = queue_q_r;
        meta_we    = 1'b1;
        meta_waddr = active_r;
        meta_wdata = {rd_idx_inc, fill - CW'(1), rstat};
        if (queue_q_r < mom_pkg::MIDI_STATUS_MIN) begin
          // Running-status data: resend the status, hold the data byte.
          if (!msg_state.in_sysex && msg_state.data_rem == 2'd0 && rstat != 8'd0) begin
            held_nxt     = queue_q_r;
            held_vld_nxt = 1'b1;
            cur_nxt      = rstat;
          end
        end else if (queue_q_r < mom_pkg::MIDI_SYS_MIN) begin
          meta_wdata[7:0] = queue_q_r;
        end else if (queue_q_r < mom_pkg::MIDI_REALTIME_MIN) begin
          meta_wdata[7:0] = 8'd0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit_en) begin
      await_nxt = !ready_r;
    end
  end

  // Result fields.
  assign emit_byte = cur_nxt;
  assign tx_go     = emit_en && ready_r;
  assign tx_byte   = tx_go ? emit_byte : 8'd0;
  assign activity  = tx_go && (emit_byte != mom_pkg::MIDI_CLOCK) &&
                     (emit_byte != mom_pkg::MIDI_ACT_SENSE);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= '0;
      held_vld_r   <= 1'b0;
      await_r      <= 1'b0;
      cur_r        <= '0;
      held_r       <= '0;
      out_vld_r    <= 1'b0;
      meta_vld_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      held_vld_r <= held_vld_nxt;
      await_r    <= await_nxt;
      cur_r      <= cur_nxt;
      held_r     <= held_nxt;
      if (res_vld) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (meta_we) begin
        meta_vld_r[meta_waddr] <= 1'b1;
      end
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_tuser;
      src_r    <= in_src_idx;
      src_ok_r <= in_src_ok;
      byte_r   <= in_tdata[11:4];
      ready_r  <= in_tdata[12];
    end
    if (res_vld) begin
      out_data_r <= {5'd0, overrun, activity, tx_byte, tx_go};
    end
  end

  // Pointer memory, read on accept.
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (accept) begin
      meta_q_r     <= meta_mem[meta_raddr];
      meta_q_vld_r <= meta_vld_r[meta_raddr];
    end
  end

  // Queue memory, single port.
  always_ff @(posedge clk) begin
    if (queue_we) begin
      queue_mem[queue_addr] <= byte_r;
    end
    if (queue_re) begin
      queue_q_r <= queue_mem[queue_addr];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
